FILE: design/fjst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the fork/join slot table.
// No dependencies; imported by fork_join_slot_table_unit and fjst_free_map.
package fjst_pkg;

    // Fixed widths of the item fields.
    localparam int OP_W    = 1;
    localparam int IDX_W   = 6;
    localparam int TAG_W   = 16;
    localparam int JOB_W   = 32;
    localparam int STAT_W  = 2;

    // Parameter defaults.
    localparam int SLOTS_DEF      = 64;
    localparam int OWNER_BITS_DEF = 16;
    localparam int JOB_BITS_DEF   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 1'b0,
        OP_ARRIVE = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_ALLOC   = 2'd0,
        ST_FULL    = 2'd1,
        ST_LEAVE   = 2'd2,
        ST_RELEASE = 2'd3
    } t_status;

    // Update request for the free-slot map.
    typedef struct packed {
        logic claim;    // clear the free bit of the lowest free slot
        logic vacate;   // set the free bit of the named slot
    } t_free_cmd;

endpackage

FILE: design/fork_join_slot_table_unit.sv
`timescale 1ns / 1ps
// Top level of the fork/join slot table.
// Depends on fjst_pkg, fjst_ram and fjst_free_map.
//
// Usage
//   Input channel: an item (operation, slot_index, owner_tag, side,
//   job_handle) is taken at a rising edge with start high and busy low.
//   Output channel: one result per item (status, slot_out, job_out) sits on
//   the o_ ports for exactly one cycle, marked by o_done. The receiver
//   cannot stall; every result must be taken in its cycle.
//   Flow: the accepting edge starts the synchronous read of the slot RAM and
//   loads the item registers; in S_EXEC the block checks, writes back and
//   registers the result. busy is high only in S_EXEC, so no new item is
//   taken before the last one is through, but a new item can be taken in
//   the cycle the previous result is shown.
//   Reset (synchronous, active low): every slot is free. Only the free
//   bitmap is cleared; RAM words are used only for slots an allocate has
//   written, so no clearing pass is needed.
//   slot_index addresses only the low 64 slots; an arrive beyond SLOTS
//   gives leave.
module fork_join_slot_table_unit #(
    parameter int SLOTS      = fjst_pkg::SLOTS_DEF,
    parameter int OWNER_BITS = fjst_pkg::OWNER_BITS_DEF,
    parameter int JOB_BITS   = fjst_pkg::JOB_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fjst_pkg::OP_W-1:0]    i_operation,
    input  logic [fjst_pkg::IDX_W-1:0]   i_slot_index,
    input  logic [fjst_pkg::TAG_W-1:0]   i_owner_tag,
    input  logic                         i_side,
    input  logic [fjst_pkg::JOB_W-1:0]   i_job_handle,
    output logic                         o_done,
    output logic [fjst_pkg::STAT_W-1:0]  o_status,
    output logic [fjst_pkg::IDX_W-1:0]   o_slot_out,
    output logic [fjst_pkg::JOB_W-1:0]   o_job_out
);
    import fjst_pkg::*;

    localparam int AW = $clog2(SLOTS);
    // RAM word: {half, first_side, owner, job}
    localparam int WORD_W   = 2 + OWNER_BITS + JOB_BITS;
    localparam int HALF_BIT = WORD_W - 1;
    localparam int SIDE_BIT = WORD_W - 2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;

    // Item held across the read cycle
    t_op                  r_op;
    logic [AW-1:0]        r_idx;
    logic                 r_idx_ok;
    logic [OWNER_BITS-1:0] r_owner;
    logic                 r_side;
    logic [JOB_BITS-1:0]  r_job;

    // Result registers
    logic                 r_done;
    t_status              r_status;
    logic [IDX_W-1:0]     r_slot_out;
    logic [JOB_W-1:0]     r_job_out;

    t_status              n_status;
    logic [IDX_W-1:0]     n_slot_out;
    logic [JOB_W-1:0]     n_job_out;

    logic                 accept;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic [WORD_W-1:0]    rd_data;

    t_free_cmd            free_cmd;
    logic                 found;
    logic [AW-1:0]        first_idx;
    logic                 query_free;

    logic                 rd_half;
    logic                 rd_side;
    logic [OWNER_BITS-1:0] rd_owner;
    logic [JOB_BITS-1:0]  rd_job;
    logic                 hit;

    assign accept = start && !busy;
    assign busy   = (r_state == S_EXEC);

    fjst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(i_slot_index)),
        .o_rd_data (rd_data)
    );

    fjst_free_map #(
        .SLOTS (SLOTS)
    ) u_free_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (free_cmd),
        .i_release_idx (r_idx),
        .i_query_idx   (r_idx),
        .o_found       (found),
        .o_first_idx   (first_idx),
        .o_query_free  (query_free)
    );

    assign rd_half  = rd_data[HALF_BIT];
    assign rd_side  = rd_data[SIDE_BIT];
    assign rd_owner = rd_data[JOB_BITS +: OWNER_BITS];
    assign rd_job   = rd_data[JOB_BITS-1:0];

    // Arrive addresses a live slot with the right owner
    assign hit = r_idx_ok && !query_free && (rd_owner == r_owner);

    // Check and write-back, active in S_EXEC only
    always_comb begin
        n_status      = ST_LEAVE;
        n_slot_out    = '0;
        n_job_out     = '0;
        wr_en         = 1'b0;
        wr_addr       = r_idx;
        wr_data       = {1'b0, 1'b0, r_owner, r_job};
        free_cmd      = '0;
        if (r_state == S_EXEC) begin
            case (r_op)
                OP_ALLOC: begin
                    if (found) begin
                        n_status      = ST_ALLOC;
                        n_slot_out    = IDX_W'(first_idx);
                        wr_en         = 1'b1;
                        wr_addr       = first_idx;
                        free_cmd.claim = 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                OP_ARRIVE: begin
                    if (hit && !rd_half) begin
                        // first arrival: record side, keep owner and job
                        wr_en   = 1'b1;
                        wr_data = {1'b1, r_side, rd_owner, rd_job};
                    end else if (hit && (rd_side != r_side)) begin
                        // other side arrived: free slot, hand back the job
                        n_status        = ST_RELEASE;
                        n_job_out       = JOB_W'(rd_job);
                        free_cmd.vacate = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_LEAVE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= t_op'(i_operation);
                        r_idx    <= AW'(i_slot_index);
                        r_idx_ok <= (32'(i_slot_index) < 32'(SLOTS));
                        r_owner  <= OWNER_BITS'(i_owner_tag);
                        r_side   <= i_side;
                        r_job    <= JOB_BITS'(i_job_handle);
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_done     <= 1'b1;
                    r_status   <= n_status;
                    r_slot_out <= n_slot_out;
                    r_job_out  <= n_job_out;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_slot_out = r_slot_out;
    assign o_job_out  = r_job_out;

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without an item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && !o_done) ##1 (o_done && !busy))
        else $error("item did not finish in two cycles");

    a_job_only_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_RELEASE)) |-> (o_job_out == '0))
        else $error("job out on non-release result");

    a_slot_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_ALLOC)) |-> (o_slot_out == '0))
        else $error("slot out on non-allocate result");

endmodule

FILE: design/fjst_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module fjst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/fjst_free_map.sv
`timescale 1ns / 1ps
// Free-slot bitmap with lowest-free priority encoder.
// Depends on fjst_pkg.
module fjst_free_map #(
    parameter int SLOTS = fjst_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  fjst_pkg::t_free_cmd      i_cmd,
    input  logic [$clog2(SLOTS)-1:0] i_release_idx,
    input  logic [$clog2(SLOTS)-1:0] i_query_idx,
    output logic                     o_found,
    output logic [$clog2(SLOTS)-1:0] o_first_idx,
    output logic                     o_query_free
);
    import fjst_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic [SLOTS-1:0] r_free;
    logic [SLOTS-1:0] n_free;
    logic [AW-1:0]    first;

    // Lowest set bit wins.
    always_comb begin
        first = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                first = AW'(i);
            end
        end
    end

    assign o_found      = |r_free;
    assign o_first_idx  = first;
    assign o_query_free = (32'(i_query_idx) < 32'(SLOTS)) ? r_free[i_query_idx] : 1'b1;

    always_comb begin
        n_free = r_free;
        if (i_cmd.claim && o_found) begin
            n_free[first] = 1'b0;
        end
        if (i_cmd.vacate && (32'(i_release_idx) < 32'(SLOTS))) begin
            n_free[i_release_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else begin
            r_free <= n_free;
        end
    end

    // A claimed slot is no longer free on the next cycle.
    a_claim_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.claim && o_found && !i_cmd.vacate) |=> !r_free[$past(first)])
        else $error("claimed slot still free");

    // Claim and vacate never meet in one cycle: one item at a time.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.claim && i_cmd.vacate))
        else $error("claim and vacate together");

endmodule

FILE: test/tb_fork_join_slot_table_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for fork_join_slot_table_unit: directed joins, a pool fill and drain,
// then random phases of allocates and arrives, all checked against a built-in slot table model.
// Depends on fjst_pkg and the design sources only.
module tb_fork_join_slot_table_unit;
    import fjst_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam int LIMIT = 200000;     // cycles

    // Per-slot phase codes and the arrival flag
    localparam logic [1:0] SLOT_IDLE   = 2'd0;
    localparam logic [1:0] SLOT_ONE_IN = 2'd1;
    localparam logic [1:0] SLOT_OPEN   = 2'd2;
    localparam logic [1:0] ARRIVED     = 2'b10;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] slot;
        logic [TAG_W-1:0] owner;
        logic             side;
        logic [JOB_W-1:0] job;
    } join_item_t;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] slot;
        logic [JOB_W-1:0] job;
    } join_result_t;

    // Scoreboard: mirrors the slot table, queues one expected result per item
    class slot_table_checker;
        logic [1:0]       phase_of [SLOTS];
        logic [TAG_W-1:0] tag_of   [SLOTS];
        logic [1:0]       mark_of  [SLOTS];
        logic [JOB_W-1:0] job_of   [SLOTS];
        join_result_t     pending_results[$];
        int               err_count;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                phase_of[i] = SLOT_IDLE;
                tag_of[i]   = '0;
                mark_of[i]  = '0;
                job_of[i]   = '0;
            end
            err_count = 0;
        endfunction

        // Apply one accepted item to the mirror and queue its result
        function void note_item(join_item_t it);
            join_result_t res;
            int           lowest;
            logic [1:0]   mine;
            res.status = ST_LEAVE;
            res.slot   = '0;
            res.job    = '0;
            if (it.op == OP_ALLOC) begin
                lowest = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (phase_of[i] == SLOT_IDLE) lowest = i;
                if (lowest < 0) begin
                    res.status = ST_FULL;
                end else begin
                    phase_of[lowest] = SLOT_OPEN;
                    tag_of[lowest]   = it.owner;
                    mark_of[lowest]  = '0;
                    job_of[lowest]   = it.job;
                    res.status       = ST_ALLOC;
                    res.slot         = lowest[IDX_W-1:0];
                end
            end else if (int'(it.slot) < SLOTS && tag_of[it.slot] == it.owner) begin
                mine = ARRIVED | {1'b0, it.side};
                if (phase_of[it.slot] == SLOT_OPEN) begin
                    phase_of[it.slot] = SLOT_ONE_IN;
                    mark_of[it.slot]  = mine;
                end else if (phase_of[it.slot] == SLOT_ONE_IN &&
                             mark_of[it.slot] == (ARRIVED | {1'b0, ~it.side})) begin
                    phase_of[it.slot] = SLOT_IDLE;
                    mark_of[it.slot]  = '0;
                    res.status        = ST_RELEASE;
                    res.job           = job_of[it.slot];
                end
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic [IDX_W-1:0] slot,
                                   logic [JOB_W-1:0] job);
            join_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d job=%h",
                         $time, status, slot, job);
                err_count++;
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                err_count++;
            end
            if (slot !== want.slot) begin
                $display("%0t: slot_out mismatch: expected %0d, actual %0d",
                         $time, want.slot, slot);
                err_count++;
            end
            if (job !== want.job) begin
                $display("%0t: job_out mismatch: expected %h, actual %h",
                         $time, want.job, job);
                err_count++;
            end
        endfunction

        // Random slot that is claimed or half joined, -1 if none
        function int pick_open_slot();
            int cand[$];
            for (int i = 0; i < SLOTS; i++)
                if (phase_of[i] != SLOT_IDLE) cand.push_back(i);
            if (cand.size() == 0) return -1;
            return cand[$urandom_range(cand.size() - 1)];
        endfunction
    endclass

    // Clock, reset and DUT pins; every input known from time zero
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_operation  = '0;
    logic [IDX_W-1:0]  i_slot_index = '0;
    logic [TAG_W-1:0]  i_owner_tag  = '0;
    logic              i_side       = 1'b0;
    logic [JOB_W-1:0]  i_job_handle = '0;
    logic              o_done;
    logic [STAT_W-1:0] o_status;
    logic [IDX_W-1:0]  o_slot_out;
    logic [JOB_W-1:0]  o_job_out;

    int cycle_count = 0;
    slot_table_checker sb = new();

    fork_join_slot_table_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_slot_index (i_slot_index),
        .i_owner_tag  (i_owner_tag),
        .i_side       (i_side),
        .i_job_handle (i_job_handle),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_slot_out   (o_slot_out),
        .o_job_out    (o_job_out)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result monitor: the strobe lasts one cycle, take it at the closing edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            sb.check_result(o_status, o_slot_out, o_job_out);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic join_item_t alloc_item(logic [TAG_W-1:0] owner, logic [JOB_W-1:0] job);
        join_item_t it;
        it.op    = OP_ALLOC;
        it.slot  = IDX_W'($urandom_range(63));   // don't care on allocate
        it.owner = owner;
        it.side  = 1'($urandom_range(1));
        it.job   = job;
        return it;
    endfunction

    function automatic join_item_t arrive_item(int idx, logic [TAG_W-1:0] owner, logic side);
        join_item_t it;
        it.op    = OP_ARRIVE;
        it.slot  = idx[IDX_W-1:0];
        it.owner = owner;
        it.side  = side;
        it.job   = $urandom();                   // ignored on arrive
        return it;
    endfunction

    // Called at a falling edge. Holds the item until busy is low at a falling
    // edge (so the next rising edge takes it), then returns after that edge.
    // start is left high so back-to-back items never toggle it.
    task automatic send_item(join_item_t it);
        start        <= 1'b1;
        i_operation  <= it.op;
        i_slot_index <= it.slot;
        i_owner_tag  <= it.owner;
        i_side       <= it.side;
        i_job_handle <= it.job;
        while (busy !== 1'b0) @(negedge i_clk);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic idle_for(int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Sender holds off until every queued result has come back
    task automatic drain_results();
        idle_for(1);
        while (sb.pending_results.size() != 0) @(negedge i_clk);
    endtask

    // One random phase. alloc_pct sets the fill pressure; most arrives are
    // well-formed joins on live slots, the rest mismatches and noise.
    task automatic run_random_phase(int count, int alloc_pct, bit gappy);
        join_item_t it;
        int         sent;
        int         burst;
        int         target;
        int         sel;
        int         idx;
        logic       side;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < count; k++) begin
                target = sb.pick_open_slot();
                sel    = $urandom_range(99);
                if ($urandom_range(99) < alloc_pct) begin
                    it = alloc_item(TAG_W'($urandom()), $urandom());
                end else if (target < 0 || sel >= 88) begin
                    it = arrive_item($urandom_range(63), TAG_W'($urandom()),
                                     1'($urandom_range(1)));
                end else if (sel < 66) begin
                    // mostly complete the join, sometimes repeat the same side
                    if (sb.phase_of[target] == SLOT_ONE_IN && $urandom_range(3) != 0)
                        side = ~sb.mark_of[target][0];
                    else
                        side = 1'($urandom_range(1));
                    it = arrive_item(target, sb.tag_of[target], side);
                end else if (sel < 77) begin
                    // wrong owner: one tag bit flipped
                    it = arrive_item(target, sb.tag_of[target] ^ (TAG_W'(1) << $urandom_range(15)),
                                     1'($urandom_range(1)));
                end else begin
                    // any slot with its stored tag; hits free slots with a matching owner
                    idx = $urandom_range(63);
                    it  = arrive_item(idx, sb.tag_of[idx], 1'($urandom_range(1)));
                end
                send_item(it);
                sent++;
            end
            if (gappy) idle_for($urandom_range(1, 5));
        end
    endtask

    initial begin
        logic       side;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extreme fields and each join outcome
        send_item(arrive_item(0, 16'h0000, 1'b0));          // never-allocated slot
        send_item(arrive_item(63, 16'hFFFF, 1'b1));         // top slot, free
        send_item(alloc_item(16'hFFFF, 32'hFFFF_FFFF));     // -> slot 0
        send_item(alloc_item(16'h0000, 32'h0000_0000));     // -> slot 1
        send_item(arrive_item(0, 16'hFFFE, 1'b0));          // owner mismatch
        send_item(arrive_item(0, 16'h7FFF, 1'b1));          // owner mismatch, top bit
        send_item(arrive_item(0, 16'hFFFF, 1'b1));          // first arrival
        send_item(arrive_item(0, 16'hFFFF, 1'b1));          // repeat from same side
        send_item(arrive_item(0, 16'hFFFF, 1'b0));          // join completes, release
        send_item(arrive_item(0, 16'hFFFF, 1'b0));          // free slot, owner still matches
        send_item(arrive_item(1, 16'h0000, 1'b0));          // first arrival, side 0
        send_item(alloc_item(16'hA5A5, 32'h5A5A_5A5A));     // lowest free is slot 0 again
        send_item(arrive_item(1, 16'h0000, 1'b0));          // repeat, side 0
        send_item(arrive_item(1, 16'h0000, 1'b1));          // release job 0
        send_item(alloc_item(16'h1234, 32'h89AB_CDEF));     // -> slot 1
        send_item(alloc_item(16'h8001, 32'h8000_0001));     // -> slot 2
        idle_for(1);
        send_item(arrive_item(2, 16'h8001, 1'b0));
        idle_for(2);
        send_item(arrive_item(2, 16'h8001, 1'b1));          // release after gaps
        send_item(arrive_item(0, 16'hA5A5, 1'b0));
        send_item(arrive_item(0, 16'hA5A5, 1'b1));
        send_item(arrive_item(1, 16'h1234, 1'b1));
        send_item(arrive_item(1, 16'h1234, 1'b0));
        drain_results();

        // Fill the pool, then overflow it: pool full three times
        for (int n = 0; n < SLOTS + 3; n++)
            send_item(alloc_item(TAG_W'($urandom()), $urandom()));
        // Drain every live slot with a proper join, random gaps between
        for (int i = 0; i < SLOTS; i++) begin
            if (sb.phase_of[i] == SLOT_OPEN) begin
                side = 1'($urandom_range(1));
                send_item(arrive_item(i, sb.tag_of[i], side));
                send_item(arrive_item(i, sb.tag_of[i], ~side));
            end else if (sb.phase_of[i] == SLOT_ONE_IN) begin
                send_item(arrive_item(i, sb.tag_of[i], ~sb.mark_of[i][0]));
            end
            if ($urandom_range(3) == 0) idle_for($urandom_range(1, 4));
        end
        drain_results();

        // Random phases: vary fill pressure, one phase in four without gaps
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 3)
                0: run_random_phase(125, 20, ph % 4 != 1);
                1: run_random_phase(125, 40, ph % 4 != 1);
                default: run_random_phase(125, 65, ph % 4 != 1);
            endcase
            if ($urandom_range(1)) drain_results();
        end

        // Wrap up: wait for the last results, then a few spare cycles for strays
        drain_results();
        repeat (8) @(negedge i_clk);
        if (sb.err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
